[rtl/mlqs_pkg.sv]
`timescale 1ns / 1ps
package mlqs_pkg;
	localparam int LEVELS = 3;
	localparam int ID_W = 7;
	localparam int WORK_W = 16;
	localparam int LVL_W = 2;
	localparam int STATUS_W = 2;

	localparam logic [STATUS_W-1:0] ST_ADDED    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_REJECTED = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EXECUTED = 2'd2;
	localparam logic [STATUS_W-1:0] ST_IDLE     = 2'd3;

	localparam logic [2:0] REG_QUANTUM0 = 3'd0;
	localparam logic [2:0] REG_QUANTUM1 = 3'd1;
	localparam logic [2:0] REG_QUANTUM2 = 3'd2;
	localparam logic [2:0] REG_SERVE0   = 3'd3;
	localparam logic [2:0] REG_SERVE1   = 3'd4;
	localparam logic [2:0] REG_SERVE2   = 3'd5;

	typedef struct packed {
		logic [WORK_W-1:0]   budget_left;
		logic [LVL_W-1:0]    new_level;
		logic                moved;
		logic                finished;
		logic [WORK_W-1:0]   work_left;
		logic [WORK_W-1:0]   run_time;
		logic [LVL_W-1:0]    run_level;
		logic [ID_W-1:0]     run_task;
		logic [STATUS_W-1:0] status;
	} result_t;
endpackage

[rtl/multilevel_queue_task_scheduler.sv]
`timescale 1ns / 1ps
// Three-level feedback queue scheduler. One transaction is handled at a time. An add
// takes the accept, then the queue and work memory writes. A rejected add and an idle
// dispatch also answer from the pick state. A dispatch that runs a slice passes through
// the accept, the level pick, a registered read of the head id from the queue
// memory, a registered read of the task's remaining work, and the update and write-back.
// Task ids index a 128-entry work memory. The three level queues share one memory of
// 3*MAX_TASKS ids. A result stays in the output register until it is taken. A new
// transaction is accepted only when that register is empty or is drained in the same cycle.
module multilevel_queue_task_scheduler import mlqs_pkg::*; #(
	parameter int MAX_TASKS = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // task_id[6:0], burst[22:7], move_up[23]
	input  logic        s_tuser,   // func
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // status, run_task, run_level, run_time, work_left,
	                               // finished, moved, new_level, budget_left, zero fill
	input  logic        cfg_we,
	input  logic [2:0]  cfg_addr,
	input  logic [15:0] cfg_wdata
);
	localparam int QI_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
	localparam int CNT_W = $clog2(MAX_TASKS + 1);
	localparam int QDEPTH = LEVELS * MAX_TASKS;
	localparam int QA_W = $clog2(QDEPTH);

	typedef enum logic [2:0] {S_IDLE, S_PICK, S_HEAD, S_WORK, S_UPD} state_t;
	state_t state_q;

	logic [WORK_W-1:0] quantum_q [LEVELS];
	logic [WORK_W-1:0] serve_q [LEVELS];
	logic [QI_W-1:0]   head_q [LEVELS];
	logic [QI_W-1:0]   tail_q [LEVELS];
	logic [CNT_W-1:0]  count_q [LEVELS];
	logic [WORK_W-1:0] slice_q [LEVELS];
	logic [LVL_W-1:0]  sweep_q;
	logic [WORK_W-1:0] budget_q;
	logic              in_service_q;
	logic [CNT_W-1:0]  total_q;

	logic              func_q, up_q;
	logic [ID_W-1:0]   id_q;
	logic [WORK_W-1:0] burst_q;
	logic [ID_W-1:0]   tid_q;

	logic [WORK_W-1:0] work_mem [128];
	logic [ID_W-1:0]   queue_mem [QDEPTH];
	logic [ID_W-1:0]   qrd_s1;
	logic [WORK_W-1:0] wrd_s1;

	result_t res_q;
	logic    out_full_q;

	assign s_tready = (state_q == S_IDLE) && (!out_full_q || m_tready);
	assign m_tvalid = out_full_q;
	assign m_tdata = {{(64 - $bits(result_t)){1'b0}}, res_q};

	function automatic logic [QI_W-1:0] wrap_inc(input logic [QI_W-1:0] i);
		return (32'(i) + 1 >= MAX_TASKS) ? '0 : QI_W'(32'(i) + 1);
	endfunction

	function automatic logic [QA_W-1:0] qaddr(input logic [LVL_W-1:0] l,
	                                          input logic [QI_W-1:0] i);
		return QA_W'(32'(l) * MAX_TASKS + 32'(i));
	endfunction

	// pick combinationally from sweep position
	logic             found;
	logic [LVL_W-1:0] pick_lvl;
	always_comb begin
		logic [2:0]       s;
		logic [LVL_W-1:0] c;
		found = 1'b0;
		pick_lvl = '0;
		for (int k = LEVELS - 1; k >= 0; k--) begin
			s = 3'(sweep_q) + 3'(k);
			c = (s >= 3'(LEVELS)) ? LVL_W'(s - 3'(LEVELS)) : LVL_W'(s);
			if (count_q[c] != '0 && serve_q[c] != '0) begin
				found = 1'b1;
				pick_lvl = c;
			end
		end
	end

	// slice math on registered operands
	logic              rr;
	logic [WORK_W-1:0] execl, saved0, run, wnew, slice_new, saved;
	logic [LVL_W-1:0]  dest;
	always_comb begin
		rr = quantum_q[sweep_q] != '0;
		execl = budget_q;
		saved0 = '0;
		if (rr && slice_q[sweep_q] < budget_q) begin
			saved0 = budget_q - slice_q[sweep_q];
			execl = slice_q[sweep_q];
		end
		run = (execl < wrd_s1) ? execl : wrd_s1;
		wnew = wrd_s1 - run;
		saved = saved0 + (execl - run);
		slice_new = slice_q[sweep_q] - execl;
		priority if (sweep_q == 2'd0) dest = 2'd1;
		else if (sweep_q == 2'd2) dest = 2'd1;
		else dest = up_q ? 2'd0 : 2'd2;
	end

	logic             q_we;
	logic [QA_W-1:0]  q_wa;
	logic [ID_W-1:0]  q_wd;
	logic             w_we;
	logic [ID_W-1:0]  w_wa;
	logic [WORK_W-1:0] w_wd;
	always_comb begin
		q_we = 1'b0; q_wa = '0; q_wd = tid_q;
		w_we = 1'b0; w_wa = tid_q; w_wd = wnew;
		if (state_q == S_PICK && !func_q && total_q < CNT_W'(MAX_TASKS)) begin
			q_we = 1'b1; q_wa = qaddr(2'd0, tail_q[0]); q_wd = id_q;
			w_we = 1'b1; w_wa = id_q; w_wd = burst_q;
		end else if (state_q == S_UPD) begin
			w_we = 1'b1;
			if (wnew != '0 && rr && slice_new == '0) begin
				q_we = 1'b1; q_wa = qaddr(dest, tail_q[dest]);
			end
		end
	end

	// head id is read in S_HEAD, the task's work in S_WORK with that id as address
	always_ff @(posedge clk) begin
		if (q_we) queue_mem[q_wa] <= q_wd;
		qrd_s1 <= queue_mem[qaddr(sweep_q, head_q[sweep_q])];
		if (w_we) work_mem[w_wa] <= w_wd;
		wrd_s1 <= work_mem[qrd_s1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			quantum_q <= '{16'd8, 16'd16, 16'd0};
			serve_q <= '{16'd50, 16'd30, 16'd20};
			slice_q <= '{16'd8, 16'd16, 16'd0};
			head_q <= '{default: '0};
			tail_q <= '{default: '0};
			count_q <= '{default: '0};
			sweep_q <= '0;
			budget_q <= '0;
			in_service_q <= 1'b0;
			total_q <= '0;
			out_full_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_addr)
					REG_QUANTUM0, REG_QUANTUM1, REG_QUANTUM2: begin
						quantum_q[cfg_addr[1:0]] <= cfg_wdata;
						slice_q[cfg_addr[1:0]] <= cfg_wdata;
					end
					REG_SERVE0: serve_q[0] <= cfg_wdata;
					REG_SERVE1: serve_q[1] <= cfg_wdata;
					REG_SERVE2: serve_q[2] <= cfg_wdata;
					default: ;
				endcase
			end
			unique case (state_q)
				S_IDLE: begin
					if (m_tready) out_full_q <= 1'b0;
					if (s_tvalid && s_tready) begin
						func_q <= s_tuser;
						id_q <= s_tdata[6:0];
						burst_q <= s_tdata[22:7];
						up_q <= s_tdata[23];
						state_q <= S_PICK;
					end
				end
				S_PICK: begin
					result_t r;
					r = '0;
					if (!func_q) begin
						r.run_task = id_q;
						if (total_q >= CNT_W'(MAX_TASKS)) r.status = ST_REJECTED;
						else begin
							r.status = ST_ADDED;
							r.work_left = burst_q;
							tail_q[0] <= wrap_inc(tail_q[0]);
							count_q[0] <= count_q[0] + 1'b1;
							total_q <= total_q + 1'b1;
						end
						out_full_q <= 1'b1;
						state_q <= S_IDLE;
					end else if (in_service_q) state_q <= S_HEAD;
					else if (!found) begin
						sweep_q <= '0;
						budget_q <= '0;
						r.status = ST_IDLE;
						out_full_q <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						sweep_q <= pick_lvl;
						budget_q <= serve_q[pick_lvl];
						in_service_q <= 1'b1;
						state_q <= S_HEAD;
					end
					res_q <= r;
				end
				S_HEAD: begin
					state_q <= S_WORK;
				end
				S_WORK: begin
					tid_q <= qrd_s1;
					state_q <= S_UPD;
				end
				S_UPD: begin
					logic [CNT_W-1:0] cnt;
					result_t r;
					cnt = count_q[sweep_q];
					r = '0;
					r.status = ST_EXECUTED;
					r.run_task = tid_q;
					r.run_level = sweep_q;
					r.run_time = run;
					r.work_left = wnew;
					r.budget_left = saved;
					if (wnew == '0) begin
						head_q[sweep_q] <= wrap_inc(head_q[sweep_q]);
						cnt = cnt - 1'b1;
						slice_q[sweep_q] <= quantum_q[sweep_q];
						if (total_q != '0) total_q <= total_q - 1'b1;
						r.finished = 1'b1;
					end else if (rr && slice_new == '0) begin
						head_q[sweep_q] <= wrap_inc(head_q[sweep_q]);
						cnt = cnt - 1'b1;
						slice_q[sweep_q] <= quantum_q[sweep_q];
						tail_q[dest] <= wrap_inc(tail_q[dest]);
						count_q[dest] <= count_q[dest] + 1'b1;
						r.moved = 1'b1;
						r.new_level = dest;
					end else if (rr) begin
						slice_q[sweep_q] <= slice_new;
					end
					count_q[sweep_q] <= cnt;
					budget_q <= saved;
					if (saved == '0 || cnt == '0) begin
						in_service_q <= 1'b0;
						sweep_q <= (sweep_q == 2'd2) ? 2'd0 : sweep_q + 1'b1;
					end
					res_q <= r;
					out_full_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(count_q[0] + count_q[1] + count_q[2]) == total_q)
		else $error("queue counts disagree with task total");
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> state_q == S_IDLE)
		else $error("input taken while busy");
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_UPD |=> out_full_q)
		else $error("dispatch produced no result");
	assert property (@(posedge clk) disable iff (!arst_n)
		in_service_q |-> sweep_q != 2'd3)
		else $error("bad sweep level");
endmodule

[verif/multilevel_queue_task_scheduler_test.sv]
`timescale 1ns / 1ps
module multilevel_queue_task_scheduler_test;
	import mlqs_pkg::*;

	localparam int MAX_TASKS = 128;
	localparam int HOLD_CYCLES = 400;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;   // task_id[6:0], burst[22:7], move_up[23]
	logic        s_tuser;   // func
	logic        m_tvalid;
	logic        m_tready;
	logic [63:0] m_tdata;   // status, run_task, run_level, run_time, work_left,
	                        // finished, moved, new_level, budget_left, zero fill
	logic        cfg_we;
	logic [2:0]  cfg_addr;
	logic [15:0] cfg_wdata;

	multilevel_queue_task_scheduler #(.MAX_TASKS(MAX_TASKS)) dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
	);

	// scheduler state mirror
	int unsigned work_mem [MAX_TASKS];
	logic [6:0]  level_fifo [LEVELS][$];
	int unsigned quantum [LEVELS];
	int unsigned serve [LEVELS];
	int unsigned slice [LEVELS];
	int unsigned sweep, budget, task_cnt;
	bit          serving;
	int          live_cnt [MAX_TASKS];

	result_t     expected_results [$];
	int          errors;
	int          send_idle, recv_stall;
	int          hold_reqs, hold_done, hold_left;
	int          n_added, n_rejected, n_executed, n_idle, n_finished, n_moved;

	always #2 clk = ~clk;

	function automatic result_t schedule_step(bit f, logic [6:0] id, logic [15:0] burst,
			bit up);
		result_t r;
		int unsigned lv, tid, execl, saved, w, run, dest;
		bit found, rr;
		r = '0;
		if (!f) begin
			r.run_task = id;
			if (task_cnt >= MAX_TASKS) begin
				r.status = ST_REJECTED;
				return r;
			end
			work_mem[id] = 32'(burst);
			level_fifo[0] = {level_fifo[0], id};
			task_cnt++;
			live_cnt[id]++;
			r.status = ST_ADDED;
			r.work_left = burst;
			return r;
		end
		if (!serving) begin
			found = 0;
			lv = 0;
			for (int i = 0; i < LEVELS; i++) begin
				if (!found && level_fifo[(sweep + i) % LEVELS].size() > 0 &&
						serve[(sweep + i) % LEVELS] != 0) begin
					lv = (sweep + i) % LEVELS;
					found = 1;
				end
			end
			if (!found) begin
				sweep = 0;
				budget = 0;
				r.status = ST_IDLE;
				return r;
			end
			sweep = lv;
			budget = serve[lv];
			serving = 1;
		end
		lv = sweep;
		tid = 32'(level_fifo[lv][0]);
		execl = budget;
		saved = 0;
		rr = (quantum[lv] != 0);
		if (rr && slice[lv] < execl) begin
			saved = execl - slice[lv];
			execl = slice[lv];
		end
		w = work_mem[tid];
		run = (execl < w) ? execl : w;
		w -= run;
		saved += execl - run;
		work_mem[tid] = w;
		if (rr)
			slice[lv] -= execl;
		r.status = ST_EXECUTED;
		r.run_task = 7'(tid);
		r.run_level = 2'(lv);
		r.run_time = 16'(run);
		r.work_left = 16'(w);
		if (w == 0) begin
			void'(level_fifo[lv].pop_front());
			slice[lv] = quantum[lv];
			if (task_cnt > 0)
				task_cnt--;
			if (live_cnt[tid] > 0)
				live_cnt[tid]--;
			r.finished = 1;
		end else if (rr && slice[lv] == 0) begin
			if (lv == 0)
				dest = 1;
			else if (lv == LEVELS - 1)
				dest = LEVELS - 2;
			else
				dest = up ? lv - 1 : lv + 1;
			void'(level_fifo[lv].pop_front());
			slice[lv] = quantum[lv];
			level_fifo[dest] = {level_fifo[dest], 7'(tid)};
			r.moved = 1;
			r.new_level = 2'(dest);
		end
		budget = saved & 16'hFFFF;
		r.budget_left = 16'(budget);
		if (budget == 0 || level_fifo[lv].size() == 0) begin
			serving = 0;
			sweep = (lv + 1) % LEVELS;
		end
		return r;
	endfunction

	task automatic send_item(bit f, logic [6:0] id, logic [15:0] burst, bit up);
		if ($urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < send_idle);
		end
		expected_results = {expected_results, schedule_step(f, id, burst, up)};
		s_tvalid <= 1'b1;
		s_tuser  <= f;
		s_tdata  <= {up, burst, id};
		do
			@(posedge clk);
		while (!s_tready);
	endtask

	task automatic drain();
		int guard;
		guard = 0;
		s_tvalid <= 1'b0;
		while (expected_results.size() != 0 && guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [15:0] value);
		drain();
		cfg_we    <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		if (idx < LEVELS) begin
			quantum[idx] = value;
			slice[idx] = value;
		end else begin
			serve[idx - LEVELS] = value;
		end
	endtask

	task automatic add_fresh(logic [15:0] burst);
		logic [6:0] id;
		id = 7'($urandom);
		for (int k = 0; k < 16 && live_cnt[id] != 0; k++)
			id = 7'($urandom);
		send_item(1'b0, id, burst, 1'($urandom_range(1)));
	endtask

	task automatic dispatch();
		send_item(1'b1, 7'($urandom), 16'($urandom), 1'($urandom_range(1)));
	endtask

	// well-formed traffic: adds that try for unused ids, dispatches with random noise fields
	task automatic run_mix(int n, int add_pct);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(99) < add_pct) begin
				if ($urandom_range(9) < 8)
					add_fresh(16'($urandom_range(1, 60)));
				else
					add_fresh(16'($urandom_range(1, 65535)));
			end else begin
				dispatch();
			end
		end
	endtask

	task automatic test_directed();
		dispatch();                                // empty scheduler answers idle
		send_item(1'b0, 7'd0, 16'd1, 1'b0);
		send_item(1'b0, 7'd127, 16'hFFFF, 1'b1);
		send_item(1'b0, 7'd5, 16'd0, 1'b0);        // zero burst
		send_item(1'b0, 7'd9, 16'd40, 1'b1);
		send_item(1'b0, 7'd9, 16'd12, 1'b0);       // duplicate id shares work entry
		send_item(1'b0, 7'h55, 16'h5555, 1'b1);
		send_item(1'b0, 7'h2A, 16'hAAAA, 1'b0);
		for (int i = 0; i < 16; i++)
			send_item(1'b1, 7'(i * 9), 16'(i * 4097), 1'(i));
		drain();
	endtask

	task automatic test_full();
		while (task_cnt < MAX_TASKS)
			add_fresh(16'($urandom_range(1, 6)));
		add_fresh(16'd3);                           // rejected
		send_item(1'b0, 7'd127, 16'hFFFF, 1'b1);   // rejected
		repeat (60) dispatch();
		drain();
	endtask

	task automatic test_config_sweep();
		// extremes of quantum and serve, including first come first served everywhere
		write_reg(REG_QUANTUM0, 16'd1);
		write_reg(REG_QUANTUM1, 16'hFFFF);
		write_reg(REG_QUANTUM2, 16'd3);
		write_reg(REG_SERVE0, 16'd1);
		write_reg(REG_SERVE1, 16'hFFFF);
		write_reg(REG_SERVE2, 16'd7);
		run_mix(40, 40);
		write_reg(REG_QUANTUM0, 16'd0);
		write_reg(REG_QUANTUM1, 16'd0);
		write_reg(REG_QUANTUM2, 16'd0);
		write_reg(REG_SERVE0, 16'hFFFF);
		write_reg(REG_SERVE2, 16'd1);
		run_mix(40, 40);
		// a level with no serve budget is skipped
		write_reg(REG_QUANTUM0, 16'd4);
		write_reg(REG_QUANTUM1, 16'd5);
		write_reg(REG_QUANTUM2, 16'd6);
		write_reg(REG_SERVE1, 16'd0);
		write_reg(REG_SERVE0, 16'd9);
		run_mix(35, 35);
		write_reg(REG_SERVE1, 16'd12);
		write_reg(REG_QUANTUM2, 16'hFFFF);
		run_mix(35, 35);
		drain();
	endtask

	task automatic test_random_phases();
		write_reg(REG_QUANTUM0, 16'd8);
		write_reg(REG_QUANTUM1, 16'd16);
		write_reg(REG_QUANTUM2, 16'd0);
		write_reg(REG_SERVE0, 16'd50);
		write_reg(REG_SERVE1, 16'd30);
		write_reg(REG_SERVE2, 16'd20);
		for (int ph = 0; ph < 4; ph++) begin
			send_idle  = (ph == 1 || ph == 3) ? ((ph == 1) ? 54 : 28) : 0;
			recv_stall = (ph == 2 || ph == 3) ? ((ph == 2) ? 54 : 28) : 0;
			run_mix(60, 35);
			if (ph == 1)
				write_reg(REG_QUANTUM1, 16'($urandom_range(1, 40)));
			if (ph == 2)
				write_reg(REG_SERVE0, 16'($urandom_range(1, 100)));
		end
		drain();
	endtask

	task automatic test_backpressure();
		send_idle = 0;
		recv_stall = 0;
		hold_reqs++;
		run_mix(40, 50);
		drain();                                    // sender waits for every result
		run_mix(20, 30);
		drain();
	endtask

	// output side: random stalls plus long hold-offs on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready  <= 1'b0;
			hold_left <= 0;
			hold_done <= 0;
		end else if (hold_reqs != hold_done) begin
			hold_done <= hold_reqs;
			hold_left <= HOLD_CYCLES;
			m_tready  <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_tready  <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_stall);
		end
	end

	task automatic check_field(string name, int unsigned exp_v, int unsigned act_v);
		if (exp_v != act_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, act_v);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		result_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[$bits(result_t)-1:0];
			if (expected_results.size() == 0) begin
				$error("result transaction with no expectation pending");
				errors++;
			end else begin
				want = expected_results.pop_front();
				check_field("status", want.status, got.status);
				check_field("run_task", want.run_task, got.run_task);
				check_field("run_level", want.run_level, got.run_level);
				check_field("run_time", want.run_time, got.run_time);
				check_field("work_left", want.work_left, got.work_left);
				check_field("finished", want.finished, got.finished);
				check_field("moved", want.moved, got.moved);
				check_field("new_level", want.new_level, got.new_level);
				check_field("budget_left", want.budget_left, got.budget_left);
				case (want.status)
					ST_ADDED:    n_added++;
					ST_REJECTED: n_rejected++;
					ST_EXECUTED: n_executed++;
					default:     n_idle++;
				endcase
				n_finished += want.finished;
				n_moved += want.moved;
			end
		end
	end

	initial begin
		#20ms;
		$display("FAILURE");
		$finish;
	end

	initial begin
		clk = 0;
		arst_n = 0;
		s_tvalid = 0;
		s_tdata = '0;
		s_tuser = 0;
		cfg_we = 0;
		cfg_addr = '0;
		cfg_wdata = '0;
		errors = 0;
		send_idle = 0;
		recv_stall = 0;
		hold_reqs = 0;
		quantum = '{8, 16, 0};
		serve = '{50, 30, 20};
		slice = '{8, 16, 0};
		sweep = 0;
		budget = 0;
		serving = 0;
		task_cnt = 0;
		foreach (live_cnt[i]) begin
			live_cnt[i] = 0;
			work_mem[i] = 0;
		end
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_full();
		test_config_sweep();
		test_random_phases();
		test_backpressure();
		drain();

		$display("covered %0d adds (%0d rejected when full), %0d slices, %0d idle dispatches",
			n_added, n_rejected, n_executed, n_idle);
		$display("%0d tasks finished, %0d level moves, six registers swept to extremes",
			n_finished, n_moved);
		if (errors == 0 && expected_results.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule
